[rtl/tsp_pkg.sv]
// package for the timestamp parser: widths, character codes, phase and step codes,
// and the controller-to-datapath command struct
// depends on nothing
`timescale 1ns / 1ps

package tsp_pkg;

	// width of each time field accumulator (valid range 8..32)
	localparam int FIELD_BITS = 20;
	localparam int TIME_BITS  = 47;
	localparam int FRAC_BITS  = 10;

	// bound on the running total: 24d+h needs 5 more bits, each *60 six more, *1000 ten more
	localparam int ACC_BITS = FIELD_BITS + 27;
	localparam int SAT_BITS = (ACC_BITS > TIME_BITS) ? ACC_BITS : TIME_BITS;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam int HOURS_PER_DAY = 24;
	localparam int MIN_PER_HOUR  = 60;
	localparam int SEC_PER_MIN   = 60;
	localparam int MS_PER_SEC    = 1000;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	// multiply-add steps of the final sum
	typedef enum logic [1:0] {
		SUM_DH,
		SUM_M,
		SUM_S,
		SUM_MS
	} step_t;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_SUM,
		ST_WAIT
	} ctrl_state_t;

	typedef struct packed {
		logic  take;  // parse the presented character
		logic  sum;   // run one multiply-add step
		step_t step;
		logic  load;  // move total to output register and clear fields
	} dp_cmd_t;

endpackage

[rtl/tsp_ctrl.sv]
// controller for the timestamp parser: state machine, step counter, output valid
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output tsp_pkg::dp_cmd_t cmd
);
	import tsp_pkg::*;

	ctrl_state_t state_q, state_d;
	step_t       step_q;
	logic        out_valid_q;
	logic        load;

	assign load = (state_q == ST_WAIT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_PARSE: begin
				if (in_valid && in_last) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (step_q == SUM_MS) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (load) begin
					state_d = ST_PARSE;
				end
			end
			default: state_d = ST_PARSE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_PARSE);
		cmd.take  = (state_q == ST_PARSE) && in_valid;
		cmd.sum   = (state_q == ST_SUM);
		cmd.step  = step_q;
		cmd.load  = load;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PARSE;
			step_q      <= SUM_DH;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SUM) begin
				step_q <= step_t'(step_q + 2'd1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/tsp_dp.sv]
// datapath for the timestamp parser: field accumulators, fraction, shared
// constant multiply-add unit for the total, output register
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsp_pkg::dp_cmd_t              cmd,
	input  logic [7:0]                    ch,
	output logic [tsp_pkg::TIME_BITS-1:0] time_ms
);
	import tsp_pkg::*;

	localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
	localparam logic [TIME_BITS-1:0]  OUT_MAX   = '1;

	logic [FIELD_BITS-1:0] days_q, hours_q, mins_q, secs_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [1:0]            fdig_q;
	phase_t                phase_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [TIME_BITS-1:0]  time_ms_q;

	logic                  is_digit;
	logic [3:0]            dv;
	logic [FIELD_BITS+3:0] sec_ext, sec_next;
	logic [FRAC_BITS-1:0]  ms;
	logic [ACC_BITS-1:0]   mul_a, prod, addend, acc_d;
	logic [TIME_BITS-1:0]  sat;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dv       = 4'(ch - CH_ZERO);
	assign sec_ext  = (FIELD_BITS+4)'(secs_q);
	assign sec_next = (sec_ext << 3) + (sec_ext << 1) + (FIELD_BITS+4)'(dv);

	// fraction scaled up for missing digits
	always_comb begin
		case (fdig_q)
			2'd0:    ms = '0;
			2'd1:    ms = FRAC_BITS'(frac_q * 10'd100);
			2'd2:    ms = FRAC_BITS'(frac_q * 10'd10);
			default: ms = frac_q;
		endcase
	end

	// operand select for the shared multiply-add, constant products as shift-add
	always_comb begin
		unique case (cmd.step)
			SUM_DH: begin
				// x24
				mul_a  = ACC_BITS'(days_q);
				prod   = (mul_a << 4) + (mul_a << 3);
				addend = ACC_BITS'(hours_q);
			end
			SUM_M: begin
				// x60
				mul_a  = acc_q;
				prod   = (mul_a << 6) - (mul_a << 2);
				addend = ACC_BITS'(mins_q);
			end
			SUM_S: begin
				// x60
				mul_a  = acc_q;
				prod   = (mul_a << 6) - (mul_a << 2);
				addend = ACC_BITS'(secs_q);
			end
			default: begin
				// x1000
				mul_a  = acc_q;
				prod   = (mul_a << 10) - (mul_a << 4) - (mul_a << 3);
				addend = ACC_BITS'(ms);
			end
		endcase
		acc_d = prod + addend;
	end

	assign sat = (SAT_BITS'(acc_q) > SAT_BITS'(OUT_MAX)) ? OUT_MAX : TIME_BITS'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_q  <= '0;
			hours_q <= '0;
			mins_q  <= '0;
			secs_q  <= '0;
			frac_q  <= '0;
			fdig_q  <= '0;
			phase_q <= PH_INT;
		end else if (cmd.load) begin
			days_q  <= '0;
			hours_q <= '0;
			mins_q  <= '0;
			secs_q  <= '0;
			frac_q  <= '0;
			fdig_q  <= '0;
			phase_q <= PH_INT;
		end else if (cmd.take) begin
			case (phase_q)
				PH_INT: begin
					if (is_digit) begin
						secs_q <= (sec_next > (FIELD_BITS+4)'(FIELD_MAX)) ? FIELD_MAX :
							FIELD_BITS'(sec_next);
					end else if (ch == CH_COLON) begin
						days_q  <= hours_q;
						hours_q <= mins_q;
						mins_q  <= secs_q;
						secs_q  <= '0;
					end else if (ch == CH_COMMA) begin
						phase_q <= PH_FRAC;
					end else begin
						phase_q <= PH_DONE;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						if (fdig_q != 2'd3) begin
							frac_q <= FRAC_BITS'(frac_q * 10'd10) + FRAC_BITS'(dv);
							fdig_q <= fdig_q + 2'd1;
						end
					end else begin
						phase_q <= PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// running total and output register hold payload only
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			acc_q <= acc_d;
		end
		if (cmd.load) begin
			time_ms_q <= sat;
		end
	end

	assign time_ms = time_ms_q;

endmodule

[rtl/subtitle_timestamp_parser_top.sv]
// top level of the timestamp parser: joins controller and datapath
// depends on tsp_pkg, tsp_ctrl, tsp_dp
`timescale 1ns / 1ps

// channel | signals                     | payload
// input   | in_valid, in_ready          | ch (8b ascii), last (1b end of string)
// output  | out_valid, out_ready        | time_ms (47b total milliseconds)
//
// characters are taken one per cycle while the string is being parsed
// after the request flagged last, the multiply-add steps (days*24+hours,
// *60+minutes, *60+seconds, *1000+ms) run in turn through one shared unit,
// then the output register is loaded
// in_ready drops from the last character until the total is loaded; a held
// output stalls the load, and parsing resumes once the result is registered
// reset clears all fields, the phase and the output valid at once

module subtitle_timestamp_parser_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tsp_pkg::TIME_BITS-1:0] time_ms
);
	import tsp_pkg::*;

	dp_cmd_t cmd;

	// controller decides when a character is parsed and when sum steps run
	tsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath holds the fields and forms the total
	tsp_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.ch      (ch),
		.time_ms (time_ms)
	);

endmodule

[verif/subtitle_timestamp_parser_top_test.sv]
// self-checking testbench for the timestamp parser top level: directed strings,
// then random timestamp text under several idle and backpressure patterns
// depends on tsp_pkg and subtitle_timestamp_parser_top
`timescale 1ns / 1ps

module subtitle_timestamp_parser_top_test;
	import tsp_pkg::*;

	// longest run of cycles with no request moving on either side
	localparam int QUIET_LIMIT = 2000;
	// cycles still waited once every owed total has arrived, to cover the tail
	localparam int TAIL_CYCLES = 12;
	localparam logic [63:0] FIELD_CAP = (64'd1 << FIELD_BITS) - 64'd1;
	localparam logic [63:0] TIME_CAP  = (64'd1 << TIME_BITS) - 64'd1;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           ch;
	logic                 last;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [TIME_BITS-1:0] time_ms;

	subtitle_timestamp_parser_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.time_ms   (time_ms)
	);

	// shadow copy of the parse state, advanced on every accepted request
	logic [FIELD_BITS-1:0] acc_days;
	logic [FIELD_BITS-1:0] acc_hours;
	logic [FIELD_BITS-1:0] acc_minutes;
	logic [FIELD_BITS-1:0] acc_seconds;
	logic [FRAC_BITS-1:0]  frac_val;
	logic [1:0]            frac_cnt;
	phase_t                parse_phase;

	// millisecond totals still owed by the block, oldest first
	logic [TIME_BITS-1:0] expected_ms[$];

	int mismatches    = 0;
	int send_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// clear the shadow state, as the block does after each result
	task automatic clear_parse();
		acc_days    = '0;
		acc_hours   = '0;
		acc_minutes = '0;
		acc_seconds = '0;
		frac_val    = '0;
		frac_cnt    = '0;
		parse_phase = PH_INT;
	endtask

	// apply one character to the shadow state; on the last flag, queue the total
	task automatic advance_parse(input logic [7:0] c, input logic is_last);
		logic        is_digit;
		logic [63:0] digit;
		logic [63:0] widened;
		logic [63:0] ms;
		logic [63:0] total;
		int          n;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		digit    = 64'(c - CH_ZERO);
		case (parse_phase)
			PH_INT: begin
				if (is_digit) begin
					// seconds accumulator saturates instead of wrapping
					widened = 64'(acc_seconds) * 64'd10 + digit;
					acc_seconds = (widened > FIELD_CAP) ? FIELD_CAP[FIELD_BITS-1:0]
						: widened[FIELD_BITS-1:0];
				end else if (c == CH_COLON) begin
					acc_days    = acc_hours;
					acc_hours   = acc_minutes;
					acc_minutes = acc_seconds;
					acc_seconds = '0;
				end else if (c == CH_COMMA) begin
					parse_phase = PH_FRAC;
				end else begin
					parse_phase = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					// only milliseconds are kept, further digits fall away
					if (frac_cnt < 2'd3) begin
						frac_val = FRAC_BITS'(frac_val * 10 + digit);
						frac_cnt = frac_cnt + 2'd1;
					end
				end else begin
					parse_phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		if (is_last) begin
			ms = 64'(frac_val);
			for (n = frac_cnt; n < 3; n++)
				ms = ms * 64'd10;
			total = 64'(acc_days) * HOURS_PER_DAY + 64'(acc_hours);
			total = total * MIN_PER_HOUR + 64'(acc_minutes);
			total = total * SEC_PER_MIN + 64'(acc_seconds);
			total = total * MS_PER_SEC + ms;
			if (total > TIME_CAP)
				total = TIME_CAP;
			expected_ms = {expected_ms, total[TIME_BITS-1:0]};
			clear_parse();
		end
	endtask

	// offer one character request, with random idle cycles ahead of it,
	// and return once the block has taken it; valid stays high afterwards
	task automatic push_char(input logic [7:0] c, input logic is_last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		ch       = c;
		last     = is_last;
		do
			@(posedge clk);
		while (!in_ready);
		advance_parse(c, is_last);
	endtask

	// send a whole string with the last flag on its final character
	task automatic push_text(input string text);
		int i;
		for (i = 0; i < text.len(); i++)
			push_char(text[i], i == text.len() - 1);
	endtask

	// drop valid and hold the input side until every owed total has arrived
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_ms.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// one random string; mostly well-formed stamps with random digits,
	// some noise and some stamps broken by a stray byte
	task automatic push_random_stamp(output int n_sent);
		logic [7:0] text[$];
		int         style;
		int         n_fields;
		int         n_digits;
		int         f;
		int         i;
		style = $urandom_range(0, 9);
		if (style == 0) begin
			repeat ($urandom_range(1, 6))
				text = {text, 8'($urandom_range(0, 255))};
		end else begin
			n_fields = $urandom_range(1, 5);
			for (f = 0; f < n_fields; f++) begin
				if (f != 0)
					text = {text, CH_COLON};
				// now and then a long run of digits to reach the saturation point
				n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9)
					: $urandom_range(0, 3);
				repeat (n_digits)
					text = {text, 8'(CH_ZERO + $urandom_range(0, 9))};
			end
			if ($urandom_range(0, 3) != 0) begin
				text = {text, CH_COMMA};
				repeat ($urandom_range(0, 5))
					text = {text, 8'(CH_ZERO + $urandom_range(0, 9))};
			end
			if (style == 1)
				text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		end
		if (text.size() == 0)
			text = {text, 8'(CH_ZERO + $urandom_range(0, 9))};
		for (i = 0; i < text.size(); i++)
			push_char(text[i], i == text.size() - 1);
		n_sent = text.size();
	endtask

	// hours, minutes, seconds and a short fraction that must be scaled up
	task automatic test_full_stamp();
		push_text("1:2:3,5");
		push_text("12:34:56,78");
		wait_drained();
	endtask

	// lowest and highest byte, a bare comma and a bare colon as whole strings
	task automatic test_char_extremes();
		push_char(8'h00, 1'b1);
		push_char(8'hFF, 1'b1);
		push_char(CH_COMMA, 1'b1);
		push_char(CH_COLON, 1'b1);
		wait_drained();
	endtask

	// seconds field pushed past its width sticks at the all-ones value
	task automatic test_field_saturation();
		push_text("99999999");
		wait_drained();
	endtask

	// digits past the third fraction digit are dropped; a stray character
	// stops the parse and the digit after it is ignored
	task automatic test_fraction_forms();
		push_text("3,12345");
		push_text("4x5");
		wait_drained();
	endtask

	// receiver holds off for a long stretch while strings keep coming, so
	// the output register fills and the input side stalls behind it
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		hold_left      = 300;
		push_text("1:00,1");
		push_text("2:00,2");
		push_text("59:59,999");
		wait_drained();
	endtask

	// random strings until about n_chars characters have been sent
	task automatic test_random_stream(input int idle_pct, input int stall_pct,
		input int n_chars);
		int sent;
		int k;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_chars) begin
			push_random_stamp(k);
			sent += k;
		end
		wait_drained();
	endtask

	// receiver side: a counted hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// compare every accepted result with the oldest owed total
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_ms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: time_ms=%0d", time_ms);
			end else begin
				if (time_ms !== expected_ms[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("time_ms mismatch: expected %0d, got %0d",
							expected_ms[0], time_ms);
				end
				void'(expected_ms.pop_front());
			end
		end
	end

	// watchdog: too long with no request moving on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("subtitle_timestamp_parser_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		ch       = '0;
		last     = 1'b0;
		clear_parse();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_full_stamp();
		test_char_extremes();
		test_field_saturation();
		test_fraction_forms();
		test_output_backpressure();
		test_random_stream(0, 0, 140);
		test_random_stream(59, 0, 140);
		test_random_stream(0, 59, 140);
		test_random_stream(31, 31, 140);

		if (mismatches == 0 && expected_ms.size() == 0)
			$display("subtitle_timestamp_parser_top_test: done, clean");
		else
			$display("subtitle_timestamp_parser_top_test: done, errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/tsp_pkg.sv
rtl/tsp_ctrl.sv
rtl/tsp_dp.sv
rtl/subtitle_timestamp_parser_top.sv
verif/subtitle_timestamp_parser_top_test.sv
